// ===== hw/rtl/rtht_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace hash table package
// Shared types, constants and hashing helpers for the trace hash table core.
// ----------------------------------------------------------------------------
package rtht_pkg;

  localparam int ENTRIES_DEF       = 1024;
  localparam int MAX_TRACE_LEN_DEF = 16;
  localparam int ADDR_WIDTH_DEF    = 32;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [14:0] COUNT_MAX = 15'd32767;

  // Operation codes.
  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_REL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_INV  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] CFG_WIN_START = 1'd0;
  localparam logic [0:0] CFG_WIN_END   = 1'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic        last_element;
    logic [10:0] entry_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_id;
    logic [31:0] trace_address;
    logic [4:0]  trace_length;
    logic        last_result;
  } out_word_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;     // latch the input word
    logic stage;       // stage the latched address and reset the byte counter
    logic hash_byte;   // fold the next byte into the running hash
    logic clr_stage;   // return staging to reset values
    logic probe_start; // load probe index from the hash
    logic probe_rd;    // issue table read at the probe index
    logic probe_next;  // advance the probe index
    logic alloc;       // write new entry metadata
    logic copy;        // copy one staged address into the trace store
    logic bump;        // raise the count of the matched entry
    logic get_rd;      // read one stored address
    logic rel_rd;      // read the entry metadata for get or release
    logic rel_wr;      // write back the decremented count
    logic emit;        // present a result word
    logic [1:0] emit_kind; // result flavour, see datapath
  } rtht_cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic op_put;
    logic op_get;
    logic op_rel;
    logic last_el;
    logic bytes_done;
    logic table_full;
    logic slot_free;
    logic slot_match;
    logic get_bad;
    logic get_done;
    logic copy_done;
    logic rel_bad;
    logic clearing;    // metadata clearing pass after reset
  } rtht_sts_t;

  localparam logic [1:0] EK_PUT = 2'd0;
  localparam logic [1:0] EK_GET = 2'd1;
  localparam logic [1:0] EK_REL = 2'd2;
  localparam logic [1:0] EK_INV = 2'd3;

endpackage

// ===== hw/rtl/refcounted_trace_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// Reference-counted trace hash table core
// Put element: the address is staged and, when kept, hashed byte by byte.
// The last element commits: the table is probed slot by slot, and for a new entry
// a slot is allocated and its trace copied; get streams the stored addresses;
// release reads and writes back the count. One word in flight; results cannot be stalled.
// Synchronous reset, then a pass over every entry clears lengths and counts.
// ----------------------------------------------------------------------------
module refcounted_trace_hash_table_core #(
  parameter int ENTRIES       = rtht_pkg::ENTRIES_DEF,
  parameter int MAX_TRACE_LEN = rtht_pkg::MAX_TRACE_LEN_DEF,
  parameter int ADDR_WIDTH    = rtht_pkg::ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rtht_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output rtht_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rtht_pkg::*;

  rtht_cmd_t cmd;
  rtht_sts_t sts;
  logic [31:0] win_start_r, win_end_r;
  logic [1:0]  hold_r;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIN_START: win_start_r <= cfg_data;
        CFG_WIN_END:   win_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Keeps busy up while a trailing get word is still in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= '0;
    else        hold_r <= {hold_r[0], cmd.get_rd};
  end

  rtht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .out_cnt_hint (hold_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  rtht_datapath #(
    .ENTRIES       (ENTRIES),
    .MAX_TRACE_LEN (MAX_TRACE_LEN),
    .ADDR_WIDTH    (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .win_start (win_start_r),
    .win_end   (win_end_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

endmodule

// ===== hw/rtl/rtht_datapath.sv =====
// ----------------------------------------------------------------------------
// Trace hash table datapath
// Staging buffer, FNV-1a hasher, entry metadata and the trace store.
// ----------------------------------------------------------------------------
module rtht_datapath #(
  parameter int ENTRIES       = rtht_pkg::ENTRIES_DEF,
  parameter int MAX_TRACE_LEN = rtht_pkg::MAX_TRACE_LEN_DEF,
  parameter int ADDR_WIDTH    = rtht_pkg::ADDR_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rtht_pkg::in_word_t  in_word,
  input  logic [31:0]         win_start,
  input  logic [31:0]         win_end,
  input  rtht_pkg::rtht_cmd_t cmd,
  output rtht_pkg::rtht_sts_t sts,
  output logic                out_valid,
  output rtht_pkg::out_word_t out_word
);
  import rtht_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(MAX_TRACE_LEN + 1);
  localparam int SW  = (MAX_TRACE_LEN > 1) ? $clog2(MAX_TRACE_LEN) : 1;
  localparam int NB  = (ADDR_WIDTH + 7) / 8;
  localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int EW  = IW + 1;
  localparam int TD  = ENTRIES * MAX_TRACE_LEN;

  // Latched input word.
  logic [1:0]            op_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic                  last_r;
  logic [10:0]           eid_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_word.operation;
      addr_r <= ADDR_WIDTH'(in_word.address);
      last_r <= in_word.last_element;
      eid_r  <= in_word.entry_id;
    end
  end

  // Staging state: the kept addresses and their running hash.
  logic [ADDR_WIDTH-1:0] stg_mem [MAX_TRACE_LEN];
  logic [31:0]           hash_r, hash_nxt;
  logic [LW-1:0]         slen_r;
  logic                  cut_r;
  logic [BW-1:0]         byte_r;
  logic                  keep_r;
  logic [ADDR_WIDTH-1:0] win_lo, win_hi;
  logic                  in_win;

  assign win_lo = ADDR_WIDTH'(win_start);
  assign win_hi = ADDR_WIDTH'(win_end);
  assign in_win = (addr_r >= win_lo) && (addr_r < win_hi);

  // One byte of FNV-1a per cycle.
  always_comb begin
    logic [7:0] b;
    b = 8'(addr_r >> (8 * byte_r));
    hash_nxt = (hash_r ^ {24'd0, b}) * FNV_PRIME;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      slen_r <= '0;
      cut_r  <= 1'b0;
      byte_r <= '0;
      keep_r <= 1'b0;
    end else if (cmd.clr_stage) begin
      hash_r <= FNV_BASIS;
      slen_r <= '0;
      cut_r  <= 1'b0;
      keep_r <= 1'b0;
    end else if (cmd.stage) begin
      byte_r <= '0;
      keep_r <= !cut_r && (slen_r < LW'(MAX_TRACE_LEN));
      if (!cut_r && (slen_r < LW'(MAX_TRACE_LEN))) begin
        slen_r <= slen_r + 1'b1;
        if (in_win) cut_r <= 1'b1;
      end
    end else if (cmd.hash_byte) begin
      if (keep_r) hash_r <= hash_nxt;
      byte_r <= byte_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage && !cut_r && (slen_r < LW'(MAX_TRACE_LEN)))
      stg_mem[SW'(slen_r)] <= addr_r;
  end

  assign sts.bytes_done = (byte_r == BW'(NB - 1)) || !keep_r;

  // Entry metadata, cleared by a pass over every entry after reset.
  logic [4:0]  len_mem  [ENTRIES];
  logic [14:0] cnt_mem  [ENTRIES];
  logic [31:0] hsh_mem  [ENTRIES];
  logic [EW-1:0] live_r;
  logic [IW-1:0] idx_r;
  logic [4:0]    rd_len_q;
  logic [14:0]   rd_cnt_q;
  logic [31:0]   rd_hsh_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] eid_ix;
  logic          eid_ok;
  logic          clr_run_r;
  logic [IW-1:0] clr_idx_r;

  assign eid_ok = (32'(eid_r) < 32'(ENTRIES));
  assign eid_ix = IW'(eid_r);
  assign rd_addr = cmd.probe_rd ? idx_r : eid_ix;
  assign rd_en   = cmd.probe_rd || cmd.rel_rd;

  // The read words are held until the next read so that the probed slot stays visible.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_len_q <= len_mem[rd_addr];
      rd_cnt_q <= cnt_mem[rd_addr];
      rd_hsh_q <= hsh_mem[rd_addr];
    end
  end

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_run_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_run_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IW'(ENTRIES - 1)) clr_run_r <= 1'b0;
    end
  end

  assign sts.clearing = clr_run_r;

  logic [4:0]  cur_len;
  logic [14:0] cur_cnt;
  assign cur_len = rd_len_q;
  assign cur_cnt = rd_cnt_q;

  always_ff @(posedge clk) begin
    if (clr_run_r) begin
      len_mem[clr_idx_r] <= '0;
      cnt_mem[clr_idx_r] <= '0;
    end else if (cmd.alloc) begin
      len_mem[idx_r] <= 5'(slen_r);
      cnt_mem[idx_r] <= 15'd1;
      hsh_mem[idx_r] <= hash_r;
    end else if (cmd.bump && cur_cnt < COUNT_MAX) begin
      cnt_mem[idx_r] <= cur_cnt + 1'b1;
    end else if (cmd.rel_wr) begin
      cnt_mem[eid_ix] <= cur_cnt - 1'b1;
    end
  end

  // The live count rises with the last copy cycle, after the put result has sampled it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cmd.copy && sts.copy_done) begin
      live_r <= live_r + 1'b1;
    end else if (cmd.rel_wr && cur_cnt == 15'd1 && live_r != '0) begin
      live_r <= live_r - 1'b1;
    end
  end

  // Probe index, starting at hash mod ENTRIES.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.probe_start) begin
      idx_r <= IW'(hash_r % ENTRIES);
    end else if (cmd.probe_next) begin
      idx_r <= (idx_r == IW'(ENTRIES - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  assign sts.table_full = (live_r >= EW'(ENTRIES));
  assign sts.slot_free  = (cur_cnt == 15'd0);
  assign sts.slot_match = (rd_hsh_q == hash_r) && (cur_len == 5'(slen_r));
  assign sts.rel_bad    = !eid_ok || (cur_cnt == 15'd0);
  assign sts.get_bad    = !eid_ok || (cur_len == 5'd0);

  // Trace store: copy on allocate, stream on get.
  logic [ADDR_WIDTH-1:0] trace_mem [TD];
  logic [LW-1:0]         cp_r;
  logic [LW-1:0]         gi_r;
  logic [ADDR_WIDTH-1:0] tr_q;
  logic [LW-1:0]         glen;
  logic [IW+SW-1:0]      ts_wa, ts_ra;

  assign glen = (cur_len > 5'(MAX_TRACE_LEN)) ? LW'(MAX_TRACE_LEN) : LW'(cur_len);
  assign ts_wa = (IW+SW)'(idx_r) * (IW+SW)'(MAX_TRACE_LEN) + (IW+SW)'(cp_r);
  assign ts_ra = (IW+SW)'(eid_ix) * (IW+SW)'(MAX_TRACE_LEN) + (IW+SW)'(gi_r);

  always_ff @(posedge clk) begin
    if (cmd.copy && cp_r < slen_r) trace_mem[ts_wa] <= stg_mem[SW'(cp_r)];
    if (cmd.get_rd) tr_q <= trace_mem[ts_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r <= '0;
      gi_r <= '0;
    end else begin
      if (cmd.capture)   cp_r <= '0;
      else if (cmd.copy) cp_r <= cp_r + 1'b1;
      if (cmd.capture)     gi_r <= '0;
      else if (cmd.get_rd) gi_r <= gi_r + 1'b1;
    end
  end

  assign sts.copy_done = (cp_r + 1'b1 >= slen_r) || (slen_r == '0);
  assign sts.get_done  = (gi_r + 1'b1 >= glen);

  assign sts.op_put  = (op_r == OP_PUT);
  assign sts.op_get  = (op_r == OP_GET);
  assign sts.op_rel  = (op_r == OP_REL);
  assign sts.last_el = last_r;

  // Result register; get words pass through the read register and get_pend_r before they are emitted.
  logic          get_pend_r;
  logic          get_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      get_pend_r <= 1'b0;
      get_last_r <= 1'b0;
    end else begin
      get_pend_r <= cmd.get_rd;
      get_last_r <= sts.get_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit || get_pend_r;
  end

  always_ff @(posedge clk) begin
    if (get_pend_r) begin
      out_word.status        <= ST_OK;
      out_word.result_id     <= '0;
      out_word.trace_address <= 32'(tr_q);
      out_word.trace_length  <= 5'(glen);
      out_word.last_result   <= get_last_r;
    end else begin
      out_word.result_id     <= '0;
      out_word.trace_address <= '0;
      out_word.trace_length  <= '0;
      out_word.last_result   <= 1'b1;
      case (cmd.emit_kind)
        EK_PUT: begin
          if (sts.table_full) begin
            out_word.status <= ST_FULL;
          end else begin
            out_word.status       <= (!sts.slot_free && cur_cnt >= COUNT_MAX) ?
                                     ST_OVF : ST_OK;
            out_word.result_id    <= 10'(idx_r);
            out_word.trace_length <= 5'(slen_r);
          end
        end
        EK_REL:  out_word.status <= ST_OK;
        default: out_word.status <= ST_INV;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rtht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Trace hash table controller
// Sequences staging, probing, allocation, get streaming and release.
// ----------------------------------------------------------------------------
module rtht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          out_cnt_hint,
  input  rtht_pkg::rtht_sts_t sts,
  output rtht_pkg::rtht_cmd_t cmd
);
  import rtht_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DEC   = 12'b000000000010,
    S_HASH  = 12'b000000000100,
    S_PSTRT = 12'b000000001000,
    S_PRD   = 12'b000000010000,
    S_PCHK  = 12'b000000100000,
    S_COPY  = 12'b000001000000,
    S_GRD   = 12'b000010000000,
    S_GCHK  = 12'b000100000000,
    S_GSTR  = 12'b001000000000,
    S_RRD   = 12'b010000000000,
    S_RCHK  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE) || (out_cnt_hint != 2'd0) || sts.clearing;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.emit_kind = EK_INV;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          cmd.capture = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.op_put) begin
          cmd.stage = 1'b1;
          state_nxt = S_HASH;
        end else if (sts.op_get || sts.op_rel) begin
          cmd.rel_rd = 1'b1;
          state_nxt = sts.op_get ? S_GCHK : S_RCHK;
        end else begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HASH: begin
        cmd.hash_byte = 1'b1;
        if (sts.bytes_done) state_nxt = sts.last_el ? S_PSTRT : S_IDLE;
      end
      S_PSTRT: begin
        if (sts.table_full) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EK_PUT;
          cmd.clr_stage = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.probe_start = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        cmd.probe_rd = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (sts.slot_free) begin
          cmd.alloc = 1'b1;
          state_nxt = S_COPY;
        end else if (sts.slot_match) begin
          cmd.bump = !(sts.slot_free) && 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_kind = EK_PUT;
          cmd.clr_stage = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = EK_PUT;
          state_nxt = S_GSTR;
        end
      end
      S_GSTR: begin
        // Used only to clear staging once a fresh entry is written.
        cmd.clr_stage = 1'b1;
        state_nxt = S_IDLE;
      end
      S_GCHK: begin
        if (sts.get_bad) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_GRD;
        end
      end
      S_GRD: begin
        cmd.get_rd = 1'b1;
        if (sts.get_done) state_nxt = S_IDLE;
      end
      S_RRD: begin
        state_nxt = S_IDLE;
      end
      S_RCHK: begin
        cmd.emit = 1'b1;
        if (sts.rel_bad) begin
          cmd.emit_kind = EK_INV;
        end else begin
          cmd.emit_kind = EK_REL;
          cmd.rel_wr = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
